[sv/rtem_pkg.sv]
// shared types and constants of the exact-match route table
`default_nettype none
package rtem_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // command queue between front and back, depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key_address;
    logic [15:0] iface_in;
  } req_t;

  typedef struct packed {
    logic [15:0] iface_out;
    logic [1:0]  status;
  } rsp_t;

  // decoded command, exactly one kind flag set
  typedef struct packed {
    logic        is_lookup;
    logic        is_add;
    logic        is_delete;
    logic        is_clear;
    logic [31:0] key;
    logic [15:0] iface;
  } cmd_t;

  // queue handshake from the front toward the queue
  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

endpackage
`default_nettype wire

[sv/rtem_front.sv]
// front stage: takes requests and decodes them into table commands
`default_nettype none
module rtem_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire rtem_pkg::req_t req,
  input  wire logic          qfull,
  output rtem_pkg::qctl_t    qctl,
  output rtem_pkg::cmd_t     qcmd
);

  logic           fvalid;
  rtem_pkg::cmd_t fcmd;
  rtem_pkg::cmd_t dec;
  logic           load;

  always_comb begin
    dec           = '0;
    dec.key       = req.key_address;
    dec.iface     = req.iface_in;
    unique case (req.opcode)
      rtem_pkg::OP_LOOKUP: dec.is_lookup = 1'b1;
      rtem_pkg::OP_ADD:    dec.is_add    = 1'b1;
      rtem_pkg::OP_DELETE: dec.is_delete = 1'b1;
      rtem_pkg::OP_CLEAR:  dec.is_clear  = 1'b1;
      default:             dec.is_clear  = 1'b1;
    endcase
  end

  assign qctl.push = fvalid && !qfull;
  assign qctl.full = qfull;
  assign load      = !fvalid || qctl.push;
  assign req_stall = !load;
  assign qcmd      = fcmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (load) begin
      fvalid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && req_valid) begin
      fcmd <= dec;
    end
  end

endmodule
`default_nettype wire

[sv/rtem_queue.sv]
// short command queue between front and back
`default_nettype none
module rtem_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rtem_pkg::qctl_t qctl,
  input  wire rtem_pkg::cmd_t  wr_cmd,
  output logic                 full,
  output logic                 empty,
  input  wire logic            pop,
  output rtem_pkg::cmd_t       rd_cmd
);

  rtem_pkg::cmd_t              slots [rtem_pkg::QUEUE_DEPTH];
  logic [rtem_pkg::QPTR_W-1:0] wr_ptr;
  logic [rtem_pkg::QPTR_W-1:0] rd_ptr;
  logic [rtem_pkg::QCNT_W-1:0] count;

  assign full   = (count == rtem_pkg::QCNT_W'(rtem_pkg::QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (qctl.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (qctl.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !qctl.push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (qctl.push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // the front only pushes while its view of the queue is not full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(qctl.push && qctl.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule
`default_nettype wire

[sv/rtem_back.sv]
// back stage: table storage, parallel match, update and result register
`default_nettype none
module rtem_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           empty,
  output logic                pop,
  input  wire rtem_pkg::cmd_t cmd,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output rtem_pkg::rsp_t      rsp
);

  logic [31:0]                entry_address [rtem_pkg::TABLE_DEPTH];
  logic [15:0]                entry_iface   [rtem_pkg::TABLE_DEPTH];
  logic [rtem_pkg::CNT_W-1:0] count;

  logic                       hit;
  logic [rtem_pkg::IDX_W-1:0] pos;
  logic                       tbl_full;
  rtem_pkg::rsp_t             result;

  assign tbl_full = (count == rtem_pkg::CNT_W'(rtem_pkg::TABLE_DEPTH));
  assign pop      = !empty && (!rsp_valid || !rsp_stall);

  // newest match wins: later slots override earlier ones
  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = 0; i < rtem_pkg::TABLE_DEPTH; i++) begin
      if ((rtem_pkg::CNT_W'(i) < count) && (entry_address[i] == cmd.key)) begin
        hit = 1'b1;
        pos = rtem_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    result = '0;
    priority if (cmd.is_lookup) begin
      if (hit) begin
        result.iface_out = entry_iface[pos];
      end else begin
        result.status = rtem_pkg::ST_NOT_FOUND;
      end
    end else if (cmd.is_add) begin
      if (tbl_full) begin
        result.status = rtem_pkg::ST_FULL;
      end
    end else if (cmd.is_delete) begin
      if (!hit) begin
        result.status = rtem_pkg::ST_NOT_FOUND;
      end
    end else begin
      result.status = rtem_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (pop) begin
      if (cmd.is_clear) begin
        count <= '0;
      end else if (cmd.is_add && !tbl_full) begin
        count <= count + 1'b1;
      end else if (cmd.is_delete && hit) begin
        count <= count - 1'b1;
      end
    end
  end

  // delete closes the gap by shifting newer entries down one slot
  always_ff @(posedge clk) begin
    if (pop) begin
      if (cmd.is_add && !tbl_full) begin
        entry_address[count[rtem_pkg::IDX_W-1:0]] <= cmd.key;
        entry_iface[count[rtem_pkg::IDX_W-1:0]]   <= cmd.iface;
      end else if (cmd.is_delete && hit) begin
        for (int i = 0; i < rtem_pkg::TABLE_DEPTH - 1; i++) begin
          if ((rtem_pkg::IDX_W'(i) >= pos) && (rtem_pkg::CNT_W'(i + 1) < count)) begin
            entry_address[i] <= entry_address[i + 1];
            entry_iface[i]   <= entry_iface[i + 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp <= result;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rtem_pkg::CNT_W'(rtem_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == rtem_pkg::ST_FULL)) |-> tbl_full)
    else $error("full status with free slots");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (pop && cmd.is_clear) |=> (count == '0))
    else $error("clear left entries behind");

  a_miss_zero_iface: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != rtem_pkg::ST_OK)) |-> (rsp.iface_out == '0))
    else $error("nonzero interface on failed request");

endmodule
`default_nettype wire

[sv/route_table_exact_match.sv]
// top level of the exact-match route table
// path: the front registers a request, the queue holds it, the back registers its result
// throughput: one request per cycle without output stall; the back executes each command
// as it is popped, using a parallel compare over all table slots, with a two-entry command queue
// between decode and execution
// reset: synchronous active-high rst empties the table and the command queue
`default_nettype none
module route_table_exact_match (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire rtem_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output rtem_pkg::rsp_t      rsp
);

  rtem_pkg::qctl_t qctl;
  rtem_pkg::cmd_t  qcmd;
  rtem_pkg::cmd_t  bcmd;
  logic            qfull;
  logic            qempty;
  logic            qpop;

  rtem_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .qfull     (qfull),
    .qctl      (qctl),
    .qcmd      (qcmd)
  );

  rtem_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .qctl   (qctl),
    .wr_cmd (qcmd),
    .full   (qfull),
    .empty  (qempty),
    .pop    (qpop),
    .rd_cmd (bcmd)
  );

  rtem_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (qempty),
    .pop       (qpop),
    .cmd       (bcmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench of the exact-match route table: directed table, then random traffic
module tb_top;

  typedef struct {
    rtem_pkg::req_t r;
    int             reps;
    bit             typed;
    rtem_pkg::rsp_t want;
  } stim_row_t;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  rtem_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_stall;
  rtem_pkg::rsp_t rsp;

  // shadow copy of the table, slot 0 oldest
  logic [31:0] tbl_addr [rtem_pkg::TABLE_DEPTH];
  logic [15:0] tbl_iface [rtem_pkg::TABLE_DEPTH];
  int          tbl_count;

  rtem_pkg::rsp_t route_expect [$];
  int             err_count;
  bit             quiet;

  route_table_exact_match uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int newest_match(logic [31:0] key);
    int i;
    int hit;
    hit = -1;
    for (i = tbl_count - 1; i >= 0 && hit < 0; i--)
      if (tbl_addr[i] == key) hit = i;
    return hit;
  endfunction

  function automatic rtem_pkg::rsp_t route_predict(rtem_pkg::req_t r);
    rtem_pkg::rsp_t o;
    int             pos;
    int             i;
    o = '0;
    o.status = rtem_pkg::ST_OK;
    case (r.opcode)
      rtem_pkg::OP_LOOKUP: begin
        pos = newest_match(r.key_address);
        if (pos >= 0) o.iface_out = tbl_iface[pos];
        else o.status = rtem_pkg::ST_NOT_FOUND;
      end
      rtem_pkg::OP_ADD: begin
        if (tbl_count >= rtem_pkg::TABLE_DEPTH) begin
          o.status = rtem_pkg::ST_FULL;
        end else begin
          tbl_addr[tbl_count] = r.key_address;
          tbl_iface[tbl_count] = r.iface_in;
          tbl_count++;
        end
      end
      rtem_pkg::OP_DELETE: begin
        pos = newest_match(r.key_address);
        if (pos < 0) begin
          o.status = rtem_pkg::ST_NOT_FOUND;
        end else begin
          // close the gap, older order kept
          for (i = pos; i + 1 < tbl_count; i++) begin
            tbl_addr[i] = tbl_addr[i + 1];
            tbl_iface[i] = tbl_iface[i + 1];
          end
          tbl_count--;
        end
      end
      default: tbl_count = 0;
    endcase
    return o;
  endfunction

  function automatic stim_row_t mk_row(logic [1:0] op, logic [31:0] key, logic [15:0] ifc,
                                       int reps, bit typed, logic [15:0] w_ifc,
                                       logic [1:0] w_st);
    stim_row_t s;
    s.r.opcode = op;
    s.r.key_address = key;
    s.r.iface_in = ifc;
    s.reps = reps;
    s.typed = typed;
    s.want.iface_out = w_ifc;
    s.want.status = w_st;
    return s;
  endfunction

  task automatic send_req(input rtem_pkg::req_t r, input bit typed,
                          input rtem_pkg::rsp_t want);
    rtem_pkg::rsp_t pred;
    while (!quiet && $urandom_range(0, 99) < 32) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    // transfer done at this edge
    pred = route_predict(r);
    route_expect.push_back(typed ? want : pred);
  endtask

  always @(posedge clk) begin : rsp_check
    rtem_pkg::rsp_t want;
    rsp_stall <= !quiet && ($urandom_range(0, 99) < 32);
    if (!rst && rsp_valid && !rsp_stall) begin
      if (route_expect.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: iface_out %h status %0d", rsp.iface_out, rsp.status);
      end else begin
        want = route_expect.pop_front();
        if (rsp.iface_out !== want.iface_out || rsp.status !== want.status) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected iface_out %h status %0d, got iface_out %h status %0d",
                     want.iface_out, want.status, rsp.iface_out, rsp.status);
        end
      end
    end
  end

  initial begin
    stim_row_t      rows [$];
    rtem_pkg::req_t r;
    logic [31:0]    pool [10];
    int             n;
    int             k;
    int             pick;
    int             mode;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    quiet <= 1'b0;
    tbl_count = 0;
    mode = 0;

    rows.push_back(mk_row(rtem_pkg::OP_LOOKUP, 32'h0000_0000, 16'h0000, 1, 1,
                          16'h0000, rtem_pkg::ST_NOT_FOUND));
    rows.push_back(mk_row(rtem_pkg::OP_DELETE, 32'hFFFF_FFFF, 16'h0000, 1, 1,
                          16'h0000, rtem_pkg::ST_NOT_FOUND));
    rows.push_back(mk_row(rtem_pkg::OP_CLEAR,  32'h0000_0000, 16'h0000, 1, 1,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_ADD,    32'h0000_0000, 16'h0000, 1, 1,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_ADD,    32'hFFFF_FFFF, 16'hFFFF, 1, 1,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1, 1,
                          16'hFFFF, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_LOOKUP, 32'h0000_0000, 16'hFFFF, 1, 1,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_LOOKUP, 32'h0000_0001, 16'h0000, 1, 0,
                          16'h0000, rtem_pkg::ST_OK));
    // duplicate add shadows the older entry
    rows.push_back(mk_row(rtem_pkg::OP_ADD,    32'hFFFF_FFFF, 16'h1234, 1, 0,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1, 0,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_DELETE, 32'hFFFF_FFFF, 16'h0000, 1, 0,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1, 0,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_DELETE, 32'h0000_0000, 16'h0000, 1, 0,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_DELETE, 32'h0000_0000, 16'h0000, 1, 0,
                          16'h0000, rtem_pkg::ST_OK));
    // fill up, the last of the burst hits a full table
    rows.push_back(mk_row(rtem_pkg::OP_ADD,    32'h8000_0000, 16'h8000, 16, 0,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_ADD,    32'hAAAA_AAAA, 16'h5555, 1, 1,
                          16'h0000, rtem_pkg::ST_FULL));
    rows.push_back(mk_row(rtem_pkg::OP_LOOKUP, 32'h8000_0000, 16'h0000, 1, 0,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_LOOKUP, 32'h8000_000E, 16'h0000, 1, 0,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_DELETE, 32'h8000_0005, 16'h0000, 1, 0,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_LOOKUP, 32'h8000_0006, 16'h0000, 1, 0,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_ADD,    32'h1234_5678, 16'hABCD, 1, 0,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_ADD,    32'h5555_5555, 16'hAAAA, 1, 1,
                          16'h0000, rtem_pkg::ST_FULL));
    rows.push_back(mk_row(rtem_pkg::OP_CLEAR,  32'h0000_0000, 16'h0000, 1, 1,
                          16'h0000, rtem_pkg::ST_OK));
    rows.push_back(mk_row(rtem_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1, 1,
                          16'h0000, rtem_pkg::ST_NOT_FOUND));
    rows.push_back(mk_row(rtem_pkg::OP_ADD,    32'h0000_0000, 16'h0000, 1, 1,
                          16'h0000, rtem_pkg::ST_OK));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < rows.size(); n++) begin
      for (k = 0; k < rows[n].reps; k++) begin
        r = rows[n].r;
        r.key_address = r.key_address + 32'(k);
        r.iface_in = r.iface_in + 16'(k);
        send_req(r, rows[n].typed, rows[n].want);
      end
    end

    for (n = 0; n < 1925; n++) begin
      // new key pool and traffic mix every phase: filling, draining, balanced
      if (n % 150 == 0) begin
        for (k = 0; k < 10; k++) pool[k] = $urandom;
        mode = (n / 150) % 3;
      end
      quiet <= (n >= 800 && n < 1100);
      pick = $urandom_range(0, 99);
      case (mode)
        0: r.opcode = (pick < 50) ? rtem_pkg::OP_ADD : (pick < 80) ? rtem_pkg::OP_LOOKUP :
                      (pick < 99) ? rtem_pkg::OP_DELETE : rtem_pkg::OP_CLEAR;
        1: r.opcode = (pick < 20) ? rtem_pkg::OP_ADD : (pick < 55) ? rtem_pkg::OP_LOOKUP :
                      (pick < 99) ? rtem_pkg::OP_DELETE : rtem_pkg::OP_CLEAR;
        default: r.opcode = (pick < 35) ? rtem_pkg::OP_ADD :
                            (pick < 70) ? rtem_pkg::OP_LOOKUP :
                            (pick < 97) ? rtem_pkg::OP_DELETE : rtem_pkg::OP_CLEAR;
      endcase
      r.key_address = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, 9)] : $urandom;
      r.iface_in = 16'($urandom);
      send_req(r, 1'b0, '0);
    end
    req_valid <= 1'b0;
    quiet <= 1'b0;

    while (route_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
sv/rtem_pkg.sv
sv/rtem_front.sv
sv/rtem_queue.sv
sv/rtem_back.sv
sv/route_table_exact_match.sv
test/tb_top.sv
